// ===== hdl/dpr_pkg.sv =====
// Shared types and constants for the depth pixel reprojection core.
package dpr_pkg;

  localparam int NUM_COEF_REGS = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int SUM_W         = 64;
  localparam int PROD_W        = 61;
  localparam int COL_W         = 11;
  localparam int ROW_W         = 10;
  localparam int COLOR_W       = 24;
  localparam int DEF_OUT_ROWS  = 800;
  localparam int DEF_OUT_COLS  = 1280;

  // Register indexes of the coefficient bank.
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_B = 3'd5;

  // Projected point handed from the matrix pipeline to the divider.
  typedef struct packed {
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] z;
    logic [COLOR_W-1:0]      color;
  } dpr_xyz_t;

  // Finished pixel handed from the divider to the output register.
  typedef struct packed {
    logic               emit;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] color;
  } dpr_res_t;

endpackage

// ===== hdl/depth_pixel_reprojection_core.sv =====
// Throughput: one pixel per cycle while out_tready does not stall; every stage is registered and stalls only when full.
// Pixels that project outside the frame or onto z = 0 produce no output transfer.
// Synchronous active-low reset empties the pipeline and clears all coefficients to zero.
// Configuration writes are always accepted; unknown register indexes are ignored.
module depth_pixel_reprojection_core
  import dpr_pkg::*;
#(
  parameter int OUT_ROWS = DEF_OUT_ROWS,
  parameter int OUT_COLS = DEF_OUT_COLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // src_col, src_row, depth_mm, pixel_color
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // dst_col, dst_row, dst_color, 3 zero bits
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [NUM_COEF_REGS-1:0][CFG_DATA_W-1:0] coef_r;
  logic     mac_valid, mac_ready, div_valid, div_ready;
  dpr_xyz_t mac_data;
  dpr_res_t div_data;
  logic     out_valid_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [COLOR_W-1:0] color_r;

  // Coefficient bank.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW0_A: coef_r[0] <= cfg_data;
        REG_ROW0_B: coef_r[1] <= cfg_data;
        REG_ROW1_A: coef_r[2] <= cfg_data;
        REG_ROW1_B: coef_r[3] <= cfg_data;
        REG_ROW2_A: coef_r[4] <= cfg_data;
        REG_ROW2_B: coef_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  dpr_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .coef        (coef_r),
    .up_valid    (in_tvalid),
    .up_ready    (in_tready),
    .src_col     (in_tdata[11:0]),
    .src_row     (in_tdata[23:12]),
    .depth_mm    (in_tdata[39:24]),
    .pixel_color (in_tdata[63:40]),
    .dn_valid    (mac_valid),
    .dn_ready    (mac_ready),
    .dn_data     (mac_data)
  );

  dpr_div #(
    .OUT_ROWS (OUT_ROWS),
    .OUT_COLS (OUT_COLS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mac_valid),
    .up_ready (mac_ready),
    .up_data  (mac_data),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_data  (div_data)
  );

  // Output register; dropped pixels pass through without a transfer.
  assign div_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid && div_data.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      col_r   <= div_data.col;
      row_r   <= div_data.row;
      color_r <= div_data.color;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, color_r, row_r, col_r};

endmodule

// ===== hdl/dpr_mac.sv =====
// Four-stage matrix pipeline: forms u*d and v*d, the nine products and the row sums.
module dpr_mac
  import dpr_pkg::*;
(
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [NUM_COEF_REGS-1:0][CFG_DATA_W-1:0] coef,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic [11:0]                           src_col,
  input  logic [11:0]                           src_row,
  input  logic [15:0]                           depth_mm,
  input  logic [COLOR_W-1:0]                    pixel_color,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output dpr_xyz_t                              dn_data
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  logic [27:0]        ud_r, vd_r;
  logic [15:0]        d_r;
  logic [COLOR_W-1:0] c1_r, c2_r, c3_r;
  logic signed [PROD_W-1:0] p_r [3][3];
  logic signed [SUM_W-1:0]  s01_r [3];
  logic signed [SUM_W-1:0]  s2b_r [3];
  dpr_xyz_t                 out_r;

  // A stage loads when it is empty or the next one moves.
  assign en4 = !v4_r || dn_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v4_r;
  assign dn_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 1: pixel coordinates scaled by depth.
  always_ff @(posedge clk) begin
    if (en1) begin
      ud_r <= 28'(src_col) * 28'(depth_mm);
      vd_r <= 28'(src_row) * 28'(depth_mm);
      d_r  <= depth_mm;
      c1_r <= pixel_color;
    end
  end

  // Stage 2: one product per matrix entry.
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int r = 0; r < 3; r++) begin
        p_r[r][0] <= PROD_W'($signed(coef[2*r][31:0])) * PROD_W'($signed({1'b0, ud_r}));
        p_r[r][1] <= PROD_W'($signed(coef[2*r][63:32])) * PROD_W'($signed({1'b0, vd_r}));
        p_r[r][2] <= PROD_W'($signed(coef[2*r+1][31:0])) * PROD_W'($signed({13'd0, d_r}));
      end
      c2_r <= c1_r;
    end
  end

  // Stage 3: partial sums, offset folded into the third term.
  always_ff @(posedge clk) begin
    if (en3) begin
      for (int r = 0; r < 3; r++) begin
        s01_r[r] <= SUM_W'(p_r[r][0]) + SUM_W'(p_r[r][1]);
        s2b_r[r] <= SUM_W'(p_r[r][2]) + SUM_W'($signed(coef[2*r+1][63:32]));
      end
      c3_r <= c2_r;
    end
  end

  // Stage 4: final row sums.
  always_ff @(posedge clk) begin
    if (en4) begin
      out_r.x     <= s01_r[0] + s2b_r[0];
      out_r.y     <= s01_r[1] + s2b_r[1];
      out_r.z     <= s01_r[2] + s2b_r[2];
      out_r.color <= c3_r;
    end
  end

endmodule

// ===== hdl/dpr_div.sv =====
// Sign normalization, range classification and a pipelined restoring divider.
module dpr_div
  import dpr_pkg::*;
#(
  parameter int OUT_ROWS = DEF_OUT_ROWS,
  parameter int OUT_COLS = DEF_OUT_COLS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  dpr_xyz_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output dpr_res_t dn_data
);

  localparam int MAX_DIM = (OUT_ROWS > OUT_COLS) ? OUT_ROWS : OUT_COLS;
  localparam int QW      = $clog2(MAX_DIM + 1);
  localparam int DW      = SUM_W + QW;

  // Stage A: flip signs so that z is non-negative.
  logic vA_r, enA;
  logic signed [SUM_W-1:0] xa_r, ya_r, za_r;
  logic                    znz_a_r;
  logic [COLOR_W-1:0]      ca_r;

  // Stage B: classification and numerators.
  logic vB_r, enB;
  logic               posx_r, posy_r, zokx_r, zoky_r, ovfx_r, ovfy_r, znz_b_r;
  logic [DW-1:0]      remx_r, remy_r;
  logic [SUM_W-1:0]   zb_r;
  logic [COLOR_W-1:0] cb_r;

  // Divider stages, one quotient bit each.
  logic               vd_r [QW];
  logic               en_d [QW];
  logic [DW-1:0]      rx_r [QW];
  logic [DW-1:0]      ry_r [QW];
  logic [QW-1:0]      qx_r [QW];
  logic [QW-1:0]      qy_r [QW];
  logic [SUM_W-1:0]   zd_r [QW];
  logic [6:0]         fl_r [QW];
  logic [COLOR_W-1:0] cd_r [QW];

  logic signed [SUM_W-1:0] xs, zs;
  logic [DW-1:0]           zsh;

  assign enA      = !vA_r || enB;
  assign enB      = !vB_r || en_d[0];
  assign up_ready = enA;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vA_r <= 1'b0;
      vB_r <= 1'b0;
    end else begin
      if (enA) vA_r <= up_valid;
      if (enB) vB_r <= vA_r;
    end
  end

  always_ff @(posedge clk) begin
    if (enA) begin
      xa_r    <= up_data.z[SUM_W-1] ? -up_data.x : up_data.x;
      ya_r    <= up_data.z[SUM_W-1] ? -up_data.y : up_data.y;
      za_r    <= up_data.z[SUM_W-1] ? -up_data.z : up_data.z;
      znz_a_r <= (up_data.z != '0);
      ca_r    <= up_data.color;
    end
  end

  // A non-positive numerator rounds up to zero exactly when it exceeds -z.
  assign xs  = xa_r + za_r;
  assign zs  = ya_r + za_r;
  assign zsh = DW'(za_r) << QW;

  always_ff @(posedge clk) begin
    if (enB) begin
      posx_r  <= (xa_r > 0);
      posy_r  <= (ya_r > 0);
      zokx_r  <= (xs > 0);
      zoky_r  <= (zs > 0);
      ovfx_r  <= (DW'(xa_r) > zsh);
      ovfy_r  <= (DW'(ya_r) > zsh);
      remx_r  <= DW'(xa_r - 1);
      remy_r  <= DW'(ya_r - 1);
      zb_r    <= za_r;
      znz_b_r <= znz_a_r;
      cb_r    <= ca_r;
    end
  end

  // Restoring division of (n - 1) by z, most significant quotient bit first.
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DW-1:0]      rx_in, ry_in, dv;
    logic [QW-1:0]      qx_in, qy_in;
    logic [SUM_W-1:0]   z_in;
    logic [6:0]         f_in;
    logic [COLOR_W-1:0] c_in;
    logic               v_in, en_nx;

    if (j == 0) begin : g_first
      assign v_in  = vB_r;
      assign rx_in = remx_r;
      assign ry_in = remy_r;
      assign qx_in = '0;
      assign qy_in = '0;
      assign z_in  = zb_r;
      assign f_in  = {znz_b_r, ovfy_r, ovfx_r, zoky_r, zokx_r, posy_r, posx_r};
      assign c_in  = cb_r;
    end else begin : g_next
      assign v_in  = vd_r[j-1];
      assign rx_in = rx_r[j-1];
      assign ry_in = ry_r[j-1];
      assign qx_in = qx_r[j-1];
      assign qy_in = qy_r[j-1];
      assign z_in  = zd_r[j-1];
      assign f_in  = fl_r[j-1];
      assign c_in  = cd_r[j-1];
    end

    if (j == QW - 1) begin : g_last
      assign en_nx = dn_ready;
    end else begin : g_mid
      assign en_nx = en_d[j+1];
    end

    assign en_d[j] = !vd_r[j] || en_nx;
    assign dv      = DW'(z_in) << (QW - 1 - j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j] <= 1'b0;
      end else if (en_d[j]) begin
        vd_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en_d[j]) begin
        rx_r[j] <= (rx_in >= dv) ? rx_in - dv : rx_in;
        ry_r[j] <= (ry_in >= dv) ? ry_in - dv : ry_in;
        qx_r[j] <= qx_in | (QW'(rx_in >= dv) << (QW - 1 - j));
        qy_r[j] <= qy_in | (QW'(ry_in >= dv) << (QW - 1 - j));
        zd_r[j] <= z_in;
        fl_r[j] <= f_in;
        cd_r[j] <= c_in;
      end
    end
  end

  // Ceiling, frame check and packing of the result.
  logic [QW:0] colq, rowq;
  logic        col_ok, row_ok;
  logic [6:0]  fl;

  assign fl     = fl_r[QW-1];
  assign colq   = (QW+1)'(qx_r[QW-1]) + 1'b1;
  assign rowq   = (QW+1)'(qy_r[QW-1]) + 1'b1;
  assign col_ok = fl[0] ? (!fl[4] && (colq < (QW+1)'(OUT_COLS))) : fl[2];
  assign row_ok = fl[1] ? (!fl[5] && (rowq < (QW+1)'(OUT_ROWS))) : fl[3];

  assign dn_valid     = vd_r[QW-1];
  assign dn_data.emit = fl[6] && col_ok && row_ok;
  assign dn_data.col  = fl[0] ? COL_W'(colq) : '0;
  assign dn_data.row  = fl[1] ? ROW_W'(rowq) : '0;
  assign dn_data.color = cd_r[QW-1];

endmodule

// ===== hdl/dpr_checker.sv =====
// Port-level checks for the reprojection core, bound to the top level.
module dpr_checker
  import dpr_pkg::*;
#(
  parameter int OUT_ROWS = DEF_OUT_ROWS,
  parameter int OUT_COLS = DEF_OUT_COLS
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        cfg_ready
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output changed");

  // Every delivered pixel lies inside the target frame.
  a_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:0] < COL_W'(OUT_COLS)) && (out_tdata[20:11] < ROW_W'(OUT_ROWS)))
    else $error("output outside frame");

  // Padding bits stay zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:45] == 3'b000)
    else $error("output padding set");

  // Nothing leaves the block right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // The coefficient port never back-pressures.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind depth_pixel_reprojection_core dpr_checker #(
  .OUT_ROWS (OUT_ROWS),
  .OUT_COLS (OUT_COLS)
) u_dpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the depth pixel reprojection core.
module tb_top;
  import dpr_pkg::*;

  localparam int LATENCY     = 18;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 125;
  localparam int FRAME_COLS  = 1280;
  localparam int FRAME_ROWS  = 800;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;
  localparam int ONE_Q16 = 65536;

  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] color;
  } pixel_out_t;

  // Scoreboard: keeps its own coefficient bank and the queue of projected pixels.
  class reprojection_scoreboard;
    logic [CFG_DATA_W-1:0] coef_bank[NUM_COEF_REGS];
    pixel_out_t            projected_q[$];
    int                    errors;

    function new();
      foreach (coef_bank[i]) coef_bank[i] = '0;
      errors = 0;
    endfunction

    function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx < NUM_COEF_REGS) coef_bank[idx] = val;
    endfunction

    // One output row of the matrix: a*ud + b*vd + c*d + offset.
    function longint row_value(int r, longint ud, longint vd, longint dep);
      longint ca, cb, cc, off;
      ca  = longint'($signed(coef_bank[2*r][31:0]));
      cb  = longint'($signed(coef_bank[2*r][63:32]));
      cc  = longint'($signed(coef_bank[2*r+1][31:0]));
      off = longint'($signed(coef_bank[2*r+1][63:32]));
      return ca * ud + cb * vd + cc * dep + off;
    endfunction

    function longint ceil_quot(longint num, longint den);
      longint q, rm;
      q  = num / den;
      rm = num % den;
      if (rm != 0 && ((rm > 0) == (den > 0))) q++;
      return q;
    endfunction

    // Note an accepted pixel and queue its projection if it lands in the frame.
    function void note_pixel(logic [63:0] data);
      longint u, v, dep, x, y, z, col, row;
      pixel_out_t p;
      u   = longint'(data[11:0]);
      v   = longint'(data[23:12]);
      dep = longint'(data[39:24]);
      x = row_value(0, u * dep, v * dep, dep);
      y = row_value(1, u * dep, v * dep, dep);
      z = row_value(2, u * dep, v * dep, dep);
      if (z == 0) return;
      col = ceil_quot(x, z);
      row = ceil_quot(y, z);
      if (col < 0 || col >= FRAME_COLS || row < 0 || row >= FRAME_ROWS) return;
      p.col   = col[COL_W-1:0];
      p.row   = row[ROW_W-1:0];
      p.color = data[63:40];
      projected_q.push_back(p);
    endfunction

    // Compare an output transfer with the oldest projected pixel.
    function void check_result(logic [47:0] data);
      pixel_out_t p;
      if (projected_q.size() == 0) begin
        $error("unexpected output transfer %h", data);
        errors++;
        return;
      end
      p = projected_q.pop_front();
      if (data[10:0] !== p.col) begin
        $error("dst_col expected %0d actual %0d", p.col, data[10:0]);
        errors++;
      end
      if (data[20:11] !== p.row) begin
        $error("dst_row expected %0d actual %0d", p.row, data[20:11]);
        errors++;
      end
      if (data[44:21] !== p.color) begin
        $error("dst_color expected %h actual %h", p.color, data[44:21]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [47:0]           out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  reprojection_scoreboard sb = new();
  bit calm = 1'b0;
  int cycle_count = 0;

  depth_pixel_reprojection_core dut (.*);

  always #1 clk = ~clk;

  // Cycle limit guards against a hung pipeline.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stalls at random except during the calm stretch.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 9);
  end

  // Output transfers are sampled mid-cycle, when both handshake signals are stable.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    bit hs;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
    end while (!hs);
    sb.write_coef(idx, val);
  endtask

  function automatic logic [63:0] pair(int lo, int hi);
    return {hi, lo};
  endfunction

  // Load a full coefficient bank, plus stray writes to unused indexes.
  task automatic load_bank(logic [CFG_DATA_W-1:0] bank[NUM_COEF_REGS]);
    write_reg(REG_ROW0_A, bank[0]);
    write_reg(REG_ROW0_B, bank[1]);
    write_reg(REG_ROW1_A, bank[2]);
    write_reg(REG_ROW1_B, bank[3]);
    write_reg(REG_ROW2_A, bank[4]);
    write_reg(REG_ROW2_B, bank[5]);
    write_reg(REG_UNUSED_6, {$urandom, $urandom});
    write_reg(REG_UNUSED_7, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [11:0] u, logic [11:0] v, logic [15:0] dep,
                            logic [23:0] color);
    bit hs;
    if (!calm && $urandom_range(0, 99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {color, dep, v, u};
    in_tvalid <= 1'b1;
    do begin
      @(negedge clk);
      hs = in_tready;
      @(posedge clk);
    end while (!hs);
    sb.note_pixel({color, dep, v, u});
  endtask

  // Mostly pixels that can land in the frame, some over the full field range.
  task automatic send_random_pixels(int count);
    logic [11:0] u, v;
    logic [15:0] dep;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 75) begin
        u = 12'($urandom_range(0, 1400));
        v = 12'($urandom_range(0, 900));
        dep = 16'($urandom_range(1, 65535));
      end else begin
        u = 12'($urandom);
        v = 12'($urandom);
        dep = 16'($urandom);
      end
      if ($urandom_range(0, 99) < 5) dep = '0;
      send_pixel(u, v, dep, 24'($urandom));
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Let the pipeline empty, including pixels that produce no transfer.
  task automatic drain();
    while (sb.projected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic int spread(int center, int span);
    return center + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] bank[NUM_COEF_REGS];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coefficients at reset are zero, so z is zero and nothing comes out.
    send_pixel(12'd0, 12'd0, 16'd0, 24'h000000);
    send_random_pixels(6);
    drain();

    // Near-identity mapping with small offsets.
    bank[0] = pair(ONE_Q16, 0);
    bank[1] = pair(0, -50 * ONE_Q16);
    bank[2] = pair(0, ONE_Q16);
    bank[3] = pair(0, 30 * ONE_Q16);
    bank[4] = pair(0, 0);
    bank[5] = pair(ONE_Q16, 10 * ONE_Q16);
    load_bank(bank);
    send_pixel(12'd0, 12'd0, 16'd0, 24'hFFFFFF);
    send_pixel(12'd4095, 12'd4095, 16'd65535, 24'hFFFFFF);
    send_pixel(12'd1279, 12'd799, 16'd1000, 24'hA5A5A5);
    send_pixel(12'd1280, 12'd400, 16'd1000, 24'h5A5A5A);
    send_pixel(12'd600, 12'd800, 16'd1000, 24'h123456);
    send_pixel(12'd0, 12'd0, 16'd1, 24'h000000);
    send_pixel(12'd100, 12'd100, 16'd65535, 24'hFEDCBA);
    send_pixel(12'd640, 12'd0, 16'd2000, 24'h00FF00);
    send_pixel(12'd1, 12'd1, 16'd300, 24'hFF0000);
    send_random_pixels(PHASE_ITEMS);
    drain();

    // Negated matrix: z is negative for every nonzero depth.
    bank[0] = pair(-ONE_Q16, 0);
    bank[1] = pair(0, 0);
    bank[2] = pair(0, -ONE_Q16);
    bank[3] = pair(0, 0);
    bank[4] = pair(0, 0);
    bank[5] = pair(-ONE_Q16, 0);
    load_bank(bank);
    send_pixel(12'd500, 12'd300, 16'd777, 24'h0F0F0F);
    send_pixel(12'd0, 12'd0, 16'd0, 24'hF0F0F0);
    send_random_pixels(40);
    drain();

    // Extreme coefficients: every half at minus one, then at both limits.
    foreach (bank[i]) bank[i] = '1;
    load_bank(bank);
    send_pixel(12'd4095, 12'd4095, 16'd65535, 24'hFFFFFF);
    send_pixel(12'd0, 12'd0, 16'd0, 24'h000001);
    send_random_pixels(30);
    drain();
    foreach (bank[i]) bank[i] = 64'h7FFF_FFFF_8000_0000;
    load_bank(bank);
    send_pixel(12'd4095, 12'd4095, 16'd65535, 24'h800000);
    send_random_pixels(30);
    drain();

    // Random plausible camera pairs; one phase runs with no idling at all.
    for (int ph = 0; ph < 4; ph++) begin
      bank[0] = pair(spread(ONE_Q16, 4096), spread(0, 1024));
      bank[1] = pair(spread(0, 100) * ONE_Q16, spread(0, 2000) * ONE_Q16);
      bank[2] = pair(spread(0, 1024), spread(ONE_Q16, 4096));
      bank[3] = pair(spread(0, 100) * ONE_Q16, spread(0, 2000) * ONE_Q16);
      bank[4] = pair(spread(0, 16), spread(0, 16));
      bank[5] = pair(spread(ONE_Q16, 2000), spread(0, 500) * ONE_Q16);
      load_bank(bank);
      calm = (ph == 2);
      send_random_pixels(PHASE_ITEMS);
      drain();
      calm = 1'b0;
    end

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
